>>> hdl/kclc_pkg.sv
package kclc_pkg;

    localparam int KEY_W     = 3;
    localparam int LIGHT_W   = 10;
    localparam int DUTY_W    = 7;
    localparam int BLINK_W   = 4;
    localparam int FAIL_W    = 2;
    localparam int LED_W     = 8;
    localparam int DIGITS_W  = 3;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_DARK_THR   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHT_THR = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DARK_DUTY  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_TKS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FAIL_LIM   = 3'd4;

    localparam logic [LIGHT_W-1:0] DARK_THR_RST   = 10'd500;
    localparam logic [LIGHT_W-1:0] BRIGHT_THR_RST = 10'd750;
    localparam logic [DUTY_W-1:0]  DARK_DUTY_RST  = 7'd100;
    localparam logic [BLINK_W-1:0] BLINK_TKS_RST  = 4'd10;
    localparam logic [FAIL_W-1:0]  FAIL_LIM_RST   = 2'd3;

    localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd100;
    localparam logic [LED_W-1:0]  LED_RESET = 8'hFF;

    typedef struct packed {
        logic [LIGHT_W-1:0] dark_thr;
        logic [LIGHT_W-1:0] bright_thr;
        logic [DUTY_W-1:0]  dark_duty;
        logic [BLINK_W-1:0] blink_ticks;
        logic [FAIL_W-1:0]  fail_limit;
    } t_cfg;

    typedef struct packed {
        logic                lock_mode;
        logic [DIGITS_W-1:0] digits;
        logic                unlock;
        logic                alarm;
    } t_lock_res;

    typedef struct packed {
        logic               blinking;
        logic [LED_W-1:0]   led;
        logic [DUTY_W-1:0]  duty;
    } t_tick_res;

endpackage

>>> hdl/kclc_regs.sv
module kclc_regs
    import kclc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_thr    <= DARK_THR_RST;
            r_cfg.bright_thr  <= BRIGHT_THR_RST;
            r_cfg.dark_duty   <= DARK_DUTY_RST;
            r_cfg.blink_ticks <= BLINK_TKS_RST;
            r_cfg.fail_limit  <= FAIL_LIM_RST;
        end else if (wr_en) begin
            case (idx)
                REG_DARK_THR:   r_cfg.dark_thr    <= pwdata[LIGHT_W-1:0];
                REG_BRIGHT_THR: r_cfg.bright_thr  <= pwdata[LIGHT_W-1:0];
                REG_DARK_DUTY:  r_cfg.dark_duty   <= pwdata[DUTY_W-1:0];
                REG_BLINK_TKS:  r_cfg.blink_ticks <= pwdata[BLINK_W-1:0];
                REG_FAIL_LIM:   r_cfg.fail_limit  <= pwdata[FAIL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DARK_THR:   prdata = APB_DW'(r_cfg.dark_thr);
            REG_BRIGHT_THR: prdata = APB_DW'(r_cfg.bright_thr);
            REG_DARK_DUTY:  prdata = APB_DW'(r_cfg.dark_duty);
            REG_BLINK_TKS:  prdata = APB_DW'(r_cfg.blink_ticks);
            REG_FAIL_LIM:   prdata = APB_DW'(r_cfg.fail_limit);
            default:        prdata = '0;
        endcase
    end

endmodule

>>> hdl/kclc_lock.sv
module kclc_lock
    import kclc_pkg::*;
#(
    parameter int CODE_DIGITS = 4,
    parameter int KEY_COUNT   = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_op,
    input  logic [KEY_W-1:0] i_key,
    input  logic [FAIL_W-1:0] i_fail_limit,
    output t_lock_res        o_res
);

    localparam int CNT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CODE_DIGITS - 1);

    logic              r_mode;
    logic [CNT_W-1:0]  r_code_cnt;
    logic [CNT_W-1:0]  r_att_cnt;
    logic [FAIL_W-1:0] r_fail;
    logic [KEY_W-1:0]  r_code [CODE_DIGITS];
    logic [KEY_W-1:0]  r_att  [CODE_DIGITS];

    logic              n_mode;
    logic [CNT_W-1:0]  n_code_cnt;
    logic [CNT_W-1:0]  n_att_cnt;
    logic [FAIL_W-1:0] n_fail;
    logic [FAIL_W-1:0] fail_inc;
    logic [FAIL_W-1:0] fail_lim;
    logic              key_ok;
    logic              match;
    logic              unlock;
    logic              alarm;

    assign key_ok = (i_op == OP_KEY) && (i_key != '0) && (i_key <= KEY_W'(KEY_COUNT));
    assign fail_inc = r_fail + FAIL_W'(1);
    assign fail_lim = (i_fail_limit == '0) ? FAIL_W'(1) : i_fail_limit;

    always_comb begin
        match = (i_key == r_code[CODE_DIGITS-1]);
        for (int i = 0; i < CODE_DIGITS - 1; i++) begin
            if (r_att[i] != r_code[i]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_code_cnt = r_code_cnt;
        n_att_cnt  = r_att_cnt;
        n_fail     = r_fail;
        unlock     = 1'b0;
        alarm      = 1'b0;
        if (key_ok) begin
            if (!r_mode) begin
                if (r_code_cnt == LAST) begin
                    n_mode = 1'b1;
                end else begin
                    n_code_cnt = r_code_cnt + CNT_W'(1);
                end
            end else if (r_att_cnt == LAST) begin
                n_att_cnt = '0;
                if (match) begin
                    unlock = 1'b1;
                end else if (fail_inc >= fail_lim) begin
                    n_fail = '0;
                    alarm  = 1'b1;
                end else begin
                    n_fail = fail_inc;
                end
            end else begin
                n_att_cnt = r_att_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_code_cnt <= '0;
            r_att_cnt  <= '0;
            r_fail     <= '0;
        end else if (i_adv) begin
            r_mode     <= n_mode;
            r_code_cnt <= n_code_cnt;
            r_att_cnt  <= n_att_cnt;
            r_fail     <= n_fail;
        end
    end

    for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (i_adv && key_ok && !r_mode && (r_code_cnt == CNT_W'(g))) begin
                r_code[g] <= i_key;
            end
            if (i_adv && key_ok && r_mode && (r_att_cnt == CNT_W'(g))) begin
                r_att[g] <= i_key;
            end
        end
    end

    always_comb begin
        o_res.lock_mode = n_mode;
        o_res.digits    = n_mode ? DIGITS_W'(n_att_cnt) : DIGITS_W'(n_code_cnt);
        o_res.unlock    = unlock;
        o_res.alarm     = alarm;
    end

`ifndef SYNTHESIS
    a_mode_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode |=> r_mode)
        else $error("lock mode dropped back to setup");

    a_attempt_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && key_ok && r_mode && (r_att_cnt == LAST) |=> (r_att_cnt == '0))
        else $error("full attempt not cleared");

    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (unlock || alarm) |-> (r_mode && key_ok && !(unlock && alarm)))
        else $error("pulse outside a completed attempt");
`endif

endmodule

>>> hdl/kclc_tick.sv
module kclc_tick
    import kclc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_op,
    input  logic [LIGHT_W-1:0] i_light,
    input  logic               i_unlock,
    input  t_cfg               i_cfg,
    output t_tick_res          o_res
);

    logic               r_blink;
    logic [BLINK_W-1:0] r_blink_cnt;
    logic [LED_W-1:0]   r_led;
    logic [DUTY_W-1:0]  r_duty;

    logic               n_blink;
    logic [BLINK_W-1:0] n_blink_cnt;
    logic [LED_W-1:0]   n_led;
    logic [DUTY_W-1:0]  n_duty;
    logic [BLINK_W-1:0] cnt_inc;
    logic [BLINK_W-1:0] blink_lim;
    logic [DUTY_W-1:0]  dark_sat;

    assign cnt_inc   = r_blink_cnt + BLINK_W'(1);
    assign blink_lim = (i_cfg.blink_ticks == '0) ? BLINK_W'(1) : i_cfg.blink_ticks;
    assign dark_sat  = (i_cfg.dark_duty > DUTY_MAX) ? DUTY_MAX : i_cfg.dark_duty;

    always_comb begin
        n_blink     = r_blink;
        n_blink_cnt = r_blink_cnt;
        n_led       = r_led;
        n_duty      = r_duty;
        if (i_op == OP_TICK) begin
            if (i_light < i_cfg.dark_thr) begin
                n_duty = dark_sat;
            end else if (i_light >= i_cfg.bright_thr) begin
                n_duty = '0;
            end
            if (r_blink) begin
                n_led = ~r_led;
                if (cnt_inc >= blink_lim) begin
                    n_blink_cnt = '0;
                    n_blink     = 1'b0;
                end else begin
                    n_blink_cnt = cnt_inc;
                end
            end
        end else if (i_unlock) begin
            n_blink = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink     <= 1'b0;
            r_blink_cnt <= '0;
            r_led       <= LED_RESET;
            r_duty      <= '0;
        end else if (i_adv) begin
            r_blink     <= n_blink;
            r_blink_cnt <= n_blink_cnt;
            r_led       <= n_led;
            r_duty      <= n_duty;
        end
    end

    always_comb begin
        o_res.blinking = n_blink;
        o_res.led      = n_led;
        o_res.duty     = n_duty;
    end

endmodule

>>> hdl/keypad_code_lock_controller.sv
// Keypad code lock with post-unlock LED blink and light-following lamp duty. Each input beat is
// a key press (tuser 0, key in tdata[2:0]) or a timer tick (tuser 1, light sample in
// tdata[12:3]); each one yields exactly one result beat with the state after that item. The
// first CODE_DIGITS valid presses after reset set the stored code, later presses form attempts
// that are checked when full. Throughput is one beat per clock unless m_axis_tready stalls the
// output; a beat passes the input register, then the result register; the input register
// takes a new beat, if empty, while a result waits. Registers over APB at byte offsets 0x00
// dark threshold, 0x04 bright threshold, 0x08 dark duty, 0x0C blink ticks, 0x10 failure limit;
// write them only while no beat is in flight.
module keypad_code_lock_controller
    import kclc_pkg::*;
#(
    parameter int CODE_DIGITS = 4,
    parameter int KEY_COUNT   = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // key[2:0], light_level[12:3], zero pad
    input  logic                s_axis_tuser,  // op
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // lock_mode[0], digits_entered[3:1], unlock_pulse[4], alarm_pulse[5], blinking[6],
    // led_pattern[14:7], lamp_duty[21:15], zero pad
    output logic [M_DATA_W-1:0] m_axis_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int RES_W = 1 + DIGITS_W + 1 + 1 + 1 + LED_W + DUTY_W;

    t_cfg               cfg;
    t_lock_res          lock_res;
    t_tick_res          tick_res;

    logic               r_in_vld;
    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic [LIGHT_W-1:0] r_light;
    logic               r_out_vld;
    logic [RES_W-1:0]   r_out;
    logic               adv;

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_DATA_W'(r_out);

    kclc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kclc_lock #(
        .CODE_DIGITS (CODE_DIGITS),
        .KEY_COUNT   (KEY_COUNT)
    ) u_lock (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_op         (r_op),
        .i_key        (r_key),
        .i_fail_limit (cfg.fail_limit),
        .o_res        (lock_res)
    );

    kclc_tick u_tick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_op     (r_op),
        .i_light  (r_light),
        .i_unlock (lock_res.unlock),
        .i_cfg    (cfg),
        .o_res    (tick_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op    <= s_axis_tuser;
            r_key   <= s_axis_tdata[KEY_W-1:0];
            r_light <= s_axis_tdata[KEY_W+LIGHT_W-1:KEY_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= {tick_res.duty, tick_res.led, tick_res.blinking,
                      lock_res.alarm, lock_res.unlock, lock_res.digits, lock_res.lock_mode};
        end
    end

`ifndef SYNTHESIS
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld)
        else $error("buffered beat lost while output stalled");

    a_adv_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> m_axis_tvalid)
        else $error("processed beat produced no result");
`endif

endmodule

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kclc_pkg::*;

    localparam int NUM_DIGITS  = 4;
    localparam int NUM_KEYS    = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic [LED_W-1:0]    led;
        logic                blinking;
        logic                alarm;
        logic                unlock;
        logic [DIGITS_W-1:0] digits;
        logic                lock_mode;
    } t_lock_result;

    class t_lock_scoreboard;
        t_cfg                cfg;
        logic                lock_on;
        logic [KEY_W-1:0]    stored[NUM_DIGITS];
        logic [KEY_W-1:0]    tries[NUM_DIGITS];
        int unsigned         code_len;
        int unsigned         try_len;
        logic [FAIL_W-1:0]   fails;
        logic                blink_on;
        logic [BLINK_W-1:0]  blink_cnt;
        logic [LED_W-1:0]    leds;
        logic [DUTY_W-1:0]   duty;
        t_lock_result        expected_q[$];
        int unsigned         errors;

        function new();
            cfg.dark_thr    = DARK_THR_RST;
            cfg.bright_thr  = BRIGHT_THR_RST;
            cfg.dark_duty   = DARK_DUTY_RST;
            cfg.blink_ticks = BLINK_TKS_RST;
            cfg.fail_limit  = FAIL_LIM_RST;
            lock_on   = 1'b0;
            code_len  = 0;
            try_len   = 0;
            fails     = '0;
            blink_on  = 1'b0;
            blink_cnt = '0;
            leds      = LED_RESET;
            duty      = '0;
            errors    = 0;
            foreach (stored[i]) begin
                stored[i] = '0;
                tries[i]  = '0;
            end
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
            case (idx)
                REG_DARK_THR:   cfg.dark_thr    = val[LIGHT_W-1:0];
                REG_BRIGHT_THR: cfg.bright_thr  = val[LIGHT_W-1:0];
                REG_DARK_DUTY:  cfg.dark_duty   = val[DUTY_W-1:0];
                REG_BLINK_TKS:  cfg.blink_ticks = val[BLINK_W-1:0];
                REG_FAIL_LIM:   cfg.fail_limit  = val[FAIL_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic op, logic [KEY_W-1:0] key, logic [LIGHT_W-1:0] light);
            t_lock_result r;
            int unsigned  lim;
            bit           same;
            r = '0;
            if (op == OP_KEY) begin
                if (key >= 1 && key <= NUM_KEYS) begin
                    if (!lock_on) begin
                        if (code_len < NUM_DIGITS) begin
                            stored[code_len] = key;
                            code_len++;
                        end
                        if (code_len >= NUM_DIGITS) lock_on = 1'b1;
                    end else begin
                        if (try_len < NUM_DIGITS) begin
                            tries[try_len] = key;
                            try_len++;
                        end
                        if (try_len >= NUM_DIGITS) begin
                            same = 1'b1;
                            foreach (tries[i]) begin
                                if (tries[i] != stored[i]) same = 1'b0;
                                tries[i] = '0;
                            end
                            try_len = 0;
                            if (same) begin
                                r.unlock = 1'b1;
                                blink_on = 1'b1;
                            end else begin
                                lim   = (cfg.fail_limit == 0) ? 1 : cfg.fail_limit;
                                fails = fails + 1'b1;
                                if (fails >= lim) begin
                                    fails   = '0;
                                    r.alarm = 1'b1;
                                end
                            end
                        end
                    end
                end
            end else begin
                if (light < cfg.dark_thr)
                    duty = (cfg.dark_duty > DUTY_MAX) ? DUTY_MAX : cfg.dark_duty;
                else if (light >= cfg.bright_thr)
                    duty = '0;
                if (blink_on) begin
                    lim       = (cfg.blink_ticks == 0) ? 1 : cfg.blink_ticks;
                    leds      = ~leds;
                    blink_cnt = blink_cnt + 1'b1;
                    if (blink_cnt >= lim) begin
                        blink_cnt = '0;
                        blink_on  = 1'b0;
                    end
                end
            end
            r.lock_mode = lock_on;
            r.digits    = DIGITS_W'(lock_on ? try_len : code_len);
            r.blinking  = blink_on;
            r.led       = leds;
            r.duty      = duty;
            expected_q.push_back(r);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                report($sformatf("%s expected %0h, got %0h", name, want, got));
        endfunction

        function void check_result(logic [M_DATA_W-1:0] raw);
            t_lock_result got;
            t_lock_result want;
            got = raw[$bits(t_lock_result)-1:0];
            if (expected_q.size() == 0) begin
                report($sformatf("result beat %h with nothing expected", raw));
                return;
            end
            want = expected_q.pop_front();
            compare("lock_mode", want.lock_mode, got.lock_mode);
            compare("digits_entered", want.digits, got.digits);
            compare("unlock_pulse", want.unlock, got.unlock);
            compare("alarm_pulse", want.alarm, got.alarm);
            compare("blinking", want.blinking, got.blinking);
            compare("led_pattern", want.led, got.led);
            compare("lamp_duty", want.duty, got.duty);
            compare("pad", '0, raw[M_DATA_W-1:$bits(t_lock_result)]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = OP_KEY;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [APB_AW-1:0]   paddr         = '0;
    logic [APB_DW-1:0]   pwdata        = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    t_lock_scoreboard    sb = new();
    logic [KEY_W-1:0]    secret[NUM_DIGITS];
    bit                  calm = 1'b0;
    bit                  hold_req = 1'b0;
    int                  live_items = 0;
    int                  idle_cycles = 0;

    keypad_code_lock_controller #(
        .CODE_DIGITS(NUM_DIGITS),
        .KEY_COUNT  (NUM_KEYS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    task automatic send_beat(input logic op, input logic [KEY_W-1:0] key,
                             input logic [LIGHT_W-1:0] light);
        while (!calm && $urandom_range(0, 99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= S_DATA_W'({light, key});
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, key, light);
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key);
        if (key >= 1 && key <= NUM_KEYS) live_items++;
        send_beat(OP_KEY, key, LIGHT_W'($urandom));
    endtask

    task automatic send_tick(input logic [LIGHT_W-1:0] light);
        live_items++;
        send_beat(OP_TICK, KEY_W'($urandom), light);
    endtask

    function automatic logic [KEY_W-1:0] any_key();
        return KEY_W'($urandom_range(1, NUM_KEYS));
    endfunction

    function automatic logic [KEY_W-1:0] bad_key();
        int k;
        k = $urandom_range(0, 3);
        return KEY_W'((k == 0) ? 0 : NUM_KEYS + k);
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(input logic [APB_DW-1:0] dark, input logic [APB_DW-1:0] bright,
                                input logic [APB_DW-1:0] duty, input logic [APB_DW-1:0] blink,
                                input logic [APB_DW-1:0] fail);
        drain();
        reg_write(REG_DARK_THR, dark);
        reg_write(REG_BRIGHT_THR, bright);
        reg_write(REG_DARK_DUTY, duty);
        reg_write(REG_BLINK_TKS, blink);
        reg_write(REG_FAIL_LIM, fail);
        for (int i = int'(REG_FAIL_LIM) + 1; i < (1 << REG_IDX_W); i++)
            reg_write(REG_IDX_W'(i), $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic directed_checks();
        logic [KEY_W-1:0] wrong[NUM_DIGITS];
        send_tick('0);
        send_tick('1);
        send_tick(LIGHT_W'(600));
        send_key(KEY_W'(0));
        send_key(KEY_W'(7));
        foreach (secret[i]) secret[i] = any_key();
        foreach (secret[i]) send_key(secret[i]);
        wrong    = secret;
        wrong[0] = KEY_W'(secret[0] % NUM_KEYS + 1);
        for (int r = 0; r < 3; r++) begin
            foreach (wrong[i]) begin
                if (r == 1 && i == 2) send_key(KEY_W'(6));
                send_key(wrong[i]);
            end
        end
        foreach (secret[i]) send_key(secret[i]);
        send_tick(LIGHT_W'($urandom));
        send_tick(LIGHT_W'($urandom));
    endtask

    task automatic send_light_tick();
        logic [LIGHT_W-1:0] light;
        case ($urandom_range(0, 3))
            0: light = sb.cfg.dark_thr + LIGHT_W'($urandom_range(0, 4)) - LIGHT_W'(2);
            1: light = sb.cfg.bright_thr + LIGHT_W'($urandom_range(0, 4)) - LIGHT_W'(2);
            default: light = LIGHT_W'($urandom);
        endcase
        send_tick(light);
    endtask

    task automatic lock_traffic(input int n);
        int target;
        int pick;
        target = live_items + n;
        while (live_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_light_tick();
            end else if (pick < 55) begin
                // finish any partial attempt so the code lines up
                while (sb.try_len != 0) send_key(any_key());
                foreach (secret[i]) begin
                    if ($urandom_range(0, 9) == 0) send_key(bad_key());
                    send_key(secret[i]);
                end
            end else if (pick < 75) begin
                repeat (NUM_DIGITS) send_key(any_key());
            end else if (pick < 85) begin
                repeat ($urandom_range(1, NUM_DIGITS - 1)) send_key(any_key());
            end else begin
                send_key(bad_key());
            end
        end
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_checks();

        calm = 1'b1;
        program_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 100),
                     $urandom_range(1, 15), $urandom_range(1, 3));
        lock_traffic(110);
        calm = 1'b0;

        program_regs(0, 0, 0, 0, 0);
        lock_traffic(110);

        program_regs(1023, 1023, 127, 15, 3);
        lock_traffic(110);

        // crossed thresholds; hold off the result side so the input stalls
        program_regs(800, 300, $urandom_range(0, 127), $urandom_range(0, 15),
                     $urandom_range(0, 3));
        calm     = 1'b1;
        hold_req = 1'b1;
        lock_traffic(40);
        calm = 1'b0;
        lock_traffic(70);

        program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
        lock_traffic(130);

        program_regs(DARK_THR_RST, BRIGHT_THR_RST, DARK_DUTY_RST, BLINK_TKS_RST, FAIL_LIM_RST);
        lock_traffic(60);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> keypad_code_lock_controller.f
hdl/kclc_pkg.sv
hdl/kclc_regs.sv
hdl/kclc_lock.sv
hdl/kclc_tick.sv
hdl/keypad_code_lock_controller.sv
bench/testbench.sv
